[rtl/core/smp_pkg.sv]
// Package for the smallest missing positive block.
// Holds field widths, the default set bound and the controller state type.
// No dependencies.
`default_nettype none

package smp_pkg;

    localparam int VALUE_W       = 16;
    localparam int MISSING_W     = 11;
    localparam int MAX_COUNT_DEF = 1024;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_LOAD,
        ST_SWEEP,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[rtl/core/smp_if.sv]
// Valid/ready channel interfaces for the element stream and the result stream.
// Depends on smp_pkg for the field widths.
`default_nettype none

interface smp_item_if
    import smp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface smp_result_if
    import smp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MISSING_W-1:0] missing;

    modport source (output valid, output missing, input ready);
    modport sink   (input valid, input missing, output ready);
endinterface

`default_nettype wire

[rtl/core/smallest_missing_positive.sv]
// Top level of the smallest missing positive block.
// Depends on smp_pkg, smp_if, smp_bitmap and smp_ctrl.
//
// Elements stream in one per cycle while the controller is loading; each value in
// 1..MAX_COUNT+1 sets its bit in a one-bit presence memory and every element is
// counted, saturating at MAX_COUNT. On the element flagged last the controller
// sweeps the memory from entry 1 to MAX_COUNT+1 through its single read port,
// one entry per cycle, picking the first clear bit at or below count+1 and
// writing each entry back to zero behind the read. The result waits in an
// output register while the next set loads. After reset a clearing pass
// writes entries 1 to MAX_COUNT+1 to zero before the first transfer is
// accepted.
`default_nettype none

module smallest_missing_positive
    import smp_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    smp_item_if.sink      items,
    smp_result_if.source  results
);

    localparam int DEPTH = MAX_COUNT + 2;
    localparam int AW    = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata;

    smp_ctrl #(
        .MAX_COUNT (MAX_COUNT),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .results   (results),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    smp_bitmap #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

`default_nettype wire

[rtl/core/smp_bitmap.sv]
// Presence bitmap: one-bit synchronous memory, one write and one read port.
// Read data is registered. No dependencies beyond smp_pkg.
`default_nettype none

module smp_bitmap
    import smp_pkg::*;
#(
    parameter int DEPTH = MAX_COUNT_DEF + 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_data
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/smp_ctrl.sv]
// Controller: clears the bitmap after reset, sets bitmap bits on load, then sweeps
// the bitmap to find the answer and clear it. Depends on smp_pkg and the channel interfaces.
`default_nettype none

module smp_ctrl
    import smp_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF,
    parameter int AW        = $clog2(MAX_COUNT + 2)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    smp_item_if.sink           items,
    smp_result_if.source       results,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic               mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  wire logic          mem_rdata
);

    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(MAX_COUNT + 1);
    localparam logic [AW-1:0] FIRST_ADDR = AW'(1);
    localparam logic [CW-1:0] COUNT_MAX  = CW'(MAX_COUNT);

    state_t               state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 issued_reg, issued_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        limit_reg, limit_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        miss_reg, miss_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MISSING_W-1:0] out_missing_reg, out_missing_next;

    logic                    take;
    logic                    emit;
    logic                    in_range;
    logic [AW+VALUE_W-1:0]   value_ext;
    logic [CW-1:0]           count_inc;
    logic [MISSING_W+AW-1:0] miss_ext;

    assign take      = items.valid && items.ready;
    assign emit      = (state_reg == ST_EMIT) && (!out_valid_reg || results.ready);
    assign value_ext = (AW + VALUE_W)'(items.value);
    assign in_range  = (items.value != '0) &&
                       (32'(items.value) <= 32'(MAX_COUNT) + 32'd1);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + CW'(1);
    assign miss_ext  = (MISSING_W + AW)'(miss_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (take && items.last)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (pend_reg && pend_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        items.ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = addr_reg;
        case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
            end
            ST_LOAD:
            begin
                items.ready = 1'b1;
                mem_we      = take && in_range;
                mem_waddr   = value_ext[AW-1:0];
                mem_wdata   = 1'b1;
            end
            ST_SWEEP:
            begin
                mem_re    = !issued_reg;
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
            end
            ST_EMIT:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        addr_next        = addr_reg;
        issued_next      = issued_reg;
        pend_next        = 1'b0;
        pend_addr_next   = pend_addr_reg;
        count_next       = count_reg;
        limit_next       = limit_reg;
        found_next       = found_reg;
        miss_next        = miss_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        out_missing_next = out_missing_reg;
        case (state_reg)
            ST_INIT:
            begin
                addr_next = (addr_reg == LAST_ADDR) ? FIRST_ADDR : addr_reg + AW'(1);
            end
            ST_LOAD:
            begin
                if (take)
                begin
                    count_next = count_inc;
                    if (items.last)
                    begin
                        limit_next  = AW'(count_inc) + AW'(1);
                        addr_next   = FIRST_ADDR;
                        issued_next = 1'b0;
                        found_next  = 1'b0;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (!issued_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg;
                    if (addr_reg == LAST_ADDR)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg + AW'(1);
                    end
                end
                if (pend_reg && !found_reg && (!mem_rdata || pend_addr_reg == limit_reg))
                begin
                    found_next = 1'b1;
                    miss_next  = pend_addr_reg;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next   = 1'b1;
                    out_missing_next = miss_ext[MISSING_W-1:0];
                    count_next       = '0;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            addr_reg      <= FIRST_ADDR;
            issued_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            issued_reg    <= issued_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg   <= pend_addr_next;
        limit_reg       <= limit_next;
        miss_reg        <= miss_next;
        out_missing_reg <= out_missing_next;
    end

    assign results.valid   = out_valid_reg;
    assign results.missing = out_missing_reg;

    // Clear write and sweep read never touch the same entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("bitmap read and write collide");

    // Sweep ends only after the answer is known.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (found_reg && miss_reg != '0 && miss_reg <= limit_reg))
        else $error("sweep ended without a valid answer");

    // Element count saturates at the set bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_COUNT))
        else $error("element count overflow");

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |=> (out_valid_reg && $stable(out_missing_reg)))
        else $error("pending result lost");

endmodule

`default_nettype wire

[test/smallest_missing_positive_test.sv]
// Self-checking testbench for smallest_missing_positive: directed table, then random data sets.
// Transfers feed a local mex predictor; results are checked against it or a typed row's value.
// Depends on smp_pkg, smp_if and the smallest_missing_positive RTL.
`default_nettype none

module smallest_missing_positive_test;
    import smp_pkg::*;

    localparam int MAX_COUNT    = MAX_COUNT_DEF;
    localparam int SWEEP_CYCLES = MAX_COUNT + 3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CALM_TAIL    = 300;
    localparam int BURST_MAX    = 18;
    localparam int LONG_HOLD    = 4000;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_SET     = 8;
    localparam int BIG_SET      = 12;
    localparam int DRAIN_SET    = 60;
    localparam int DIRECTED_LEN = 25;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic                 last;
        logic                 typed;
        logic [MISSING_W-1:0] missing;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{16'd1,     1'b1, 1'b1, 11'd2},
        '{16'd0,     1'b1, 1'b1, 11'd1},
        '{16'd65535, 1'b1, 1'b1, 11'd1},
        '{16'd1025,  1'b1, 1'b1, 11'd1},
        '{16'd1024,  1'b1, 1'b1, 11'd1},
        '{16'd2,     1'b0, 1'b0, 11'd0},
        '{16'd1,     1'b1, 1'b0, 11'd0},
        '{16'd1,     1'b0, 1'b0, 11'd0},
        '{16'd1,     1'b0, 1'b0, 11'd0},
        '{16'd2,     1'b1, 1'b0, 11'd0},
        '{16'd3,     1'b0, 1'b0, 11'd0},
        '{16'd2,     1'b0, 1'b0, 11'd0},
        '{16'd1,     1'b1, 1'b0, 11'd0},
        '{16'd0,     1'b0, 1'b0, 11'd0},
        '{16'd0,     1'b0, 1'b0, 11'd0},
        '{16'd1,     1'b1, 1'b0, 11'd0},
        '{16'd65535, 1'b0, 1'b0, 11'd0},
        '{16'd32768, 1'b0, 1'b0, 11'd0},
        '{16'd1,     1'b0, 1'b0, 11'd0},
        '{16'd2,     1'b1, 1'b0, 11'd0},
        '{16'd2,     1'b0, 1'b0, 11'd0},
        '{16'd3,     1'b0, 1'b0, 11'd0},
        '{16'd4,     1'b1, 1'b0, 11'd0},
        '{16'd1026,  1'b0, 1'b0, 11'd0},
        '{16'd1,     1'b1, 1'b0, 11'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    smp_item_if   items ();
    smp_result_if results ();

    smallest_missing_positive #(
        .MAX_COUNT (MAX_COUNT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    logic [MAX_COUNT+1:0] seen_bits;
    int unsigned          seen_count;
    logic [MISSING_W-1:0] missing_due [$];
    logic [MISSING_W-1:0] missing_want;
    int unsigned          mismatches;
    bit                   calm;
    bit                   hold_request;

    always #5 clk = ~clk;

    task automatic absorb_value(input logic [VALUE_W-1:0] v, input logic is_last,
                                input logic typed, input logic [MISSING_W-1:0] typed_missing);
        int unsigned          bound;
        logic [MISSING_W-1:0] found;
        bit                   hit;
        if (v >= 1 && v <= MAX_COUNT + 1)
            seen_bits[v] = 1'b1;
        if (seen_count < MAX_COUNT)
            seen_count++;
        if (is_last)
        begin
            bound = seen_count + 1;
            found = bound[MISSING_W-1:0];
            hit   = 1'b0;
            for (int k = 1; k <= bound; k++)
            begin
                if (!hit && !seen_bits[k])
                begin
                    found = k[MISSING_W-1:0];
                    hit   = 1'b1;
                end
            end
            missing_due.push_back(typed ? typed_missing : found);
            seen_bits  = '0;
            seen_count = 0;
        end
    endtask

    task automatic send_item(input logic [VALUE_W-1:0] v, input logic is_last,
                             input logic typed, input logic [MISSING_W-1:0] typed_missing);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            items.valid <= 1'b0;
            items.value <= VALUE_W'($urandom);
            repeat ($urandom_range(1, BURST_MAX)) @(negedge clk);
        end
        items.valid <= 1'b1;
        items.value <= v;
        items.last  <= is_last;
        do
            @(posedge clk);
        while (!items.ready);
        absorb_value(v, is_last, typed, typed_missing);
        @(negedge clk);
    endtask

    initial
    begin
        int hold_left;
        hold_left     = 0;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                results.ready <= 1'b0;
                hold_left--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                results.ready <= 1'b0;
                hold_left = $urandom_range(1, BURST_MAX) - 1;
            end
            else
                results.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            if (missing_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: missing=%0d", results.missing);
            end
            else
            begin
                missing_want = missing_due.pop_front();
                if (results.missing !== missing_want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("missing mismatch: expected %0d, actual %0d",
                                 missing_want, results.missing);
                end
            end
        end
    end

    initial
    begin
        int                 set_no;
        int                 len;
        int                 kind;
        int                 j;
        int                 random_sent;
        bit                 set_calm;
        logic [VALUE_W-1:0] tmp;
        logic [VALUE_W-1:0] set_vals [$];

        rst_n        = 1'b0;
        items.valid  = 1'b0;
        items.value  = '0;
        items.last   = 1'b0;
        seen_bits    = '0;
        seen_count   = 0;
        mismatches   = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < DIRECTED_LEN; k++)
            send_item(DIRECTED_ROWS[k].value, DIRECTED_ROWS[k].last,
                      DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].missing);

        set_no      = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            set_calm = ($urandom_range(0, 3) == 0);
            if (set_no == HOLD_SET)
                hold_request = 1'b1;
            if (set_no == DRAIN_SET && missing_due.size() != 0)
            begin
                items.valid <= 1'b0;
                while (missing_due.size() != 0) @(negedge clk);
            end

            set_vals.delete();
            if (set_no == BIG_SET)
            begin
                for (int k = 1; k <= MAX_COUNT + 1; k++)
                    set_vals.push_back(k[VALUE_W-1:0]);
                set_vals.push_back(VALUE_W'($urandom));
            end
            else
            begin
                len  = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 40) :
                       $urandom_range(1, 8);
                kind = $urandom_range(0, 3);
                for (int k = 0; k < len; k++)
                begin
                    case (kind)
                        0: set_vals.push_back(VALUE_W'($urandom_range(0, len + 2)));
                        1: set_vals.push_back(VALUE_W'(k + 1));
                        2: set_vals.push_back(VALUE_W'($urandom));
                        default: set_vals.push_back(VALUE_W'(($urandom_range(0, 1) == 0) ?
                                     $urandom_range(1, len + 1) :
                                     $urandom_range(MAX_COUNT - 1, MAX_COUNT + 2)));
                    endcase
                end
                if (kind == 1 && $urandom_range(0, 1) == 0)
                    set_vals[$urandom_range(0, len - 1)] = VALUE_W'($urandom);
            end
            for (int k = set_vals.size() - 1; k > 0; k--)
            begin
                j           = $urandom_range(0, k);
                tmp         = set_vals[k];
                set_vals[k] = set_vals[j];
                set_vals[j] = tmp;
            end

            for (int k = 0; k < set_vals.size(); k++)
            begin
                calm = set_calm || (random_sent >= RANDOM_ITEMS - CALM_TAIL);
                send_item(set_vals[k], k == set_vals.size() - 1, 1'b0, '0);
                random_sent++;
            end
            set_no++;
        end

        items.valid <= 1'b0;
        while (missing_due.size() != 0) @(posedge clk);
        repeat (SWEEP_CYCLES + 8) @(posedge clk);
        if (mismatches == 0 && missing_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/core/smp_pkg.sv
rtl/core/smp_if.sv
rtl/core/smp_bitmap.sv
rtl/core/smp_ctrl.sv
rtl/core/smallest_missing_positive.sv
test/smallest_missing_positive_test.sv
